// ===== hdl/srg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

  localparam int unsigned ValW     = 32;
  localparam int unsigned StepW    = 16;
  localparam int unsigned TickW    = 16;
  localparam int unsigned WinW     = 21;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [StepW-1:0] RampStepReset       = 16'd197;
  localparam logic [TickW-1:0] TickPeriodReset     = 16'd262;
  localparam logic [WinW-1:0]  PositionWindowReset = 21'd6554;
  localparam logic [WinW-1:0]  SpeedWindowReset    = 21'd19661;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAMP_STEP       = 2'd0,
    CFG_TICK_PERIOD     = 2'd1,
    CFG_POSITION_WINDOW = 2'd2,
    CFG_SPEED_WINDOW    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [ValW-1:0] speed_cmd;
    logic signed [ValW-1:0] yaw_rate_cmd;
    logic signed [ValW-1:0] measured_position;
    logic signed [ValW-1:0] measured_speed;
  } tick_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] speed_target;
    logic signed [ValW-1:0] position_target;
    logic signed [ValW-1:0] yaw_target;
  } target_word_t;

  // Saturate a 34-bit signed sum to the 32-bit signed range.
  function automatic logic signed [ValW-1:0] sat32(input logic signed [ValW+1:0] v);
    logic signed [ValW+1:0] max_v;
    logic signed [ValW+1:0] min_v;
    max_v = {3'b000, {(ValW-1){1'b1}}};
    min_v = {3'b111, {(ValW-1){1'b0}}};
    if (v > max_v) begin
      return max_v[ValW-1:0];
    end else if (v < min_v) begin
      return min_v[ValW-1:0];
    end
    return v[ValW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/srg_tick_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface srg_tick_if import srg_pkg::*; ();
  logic       valid;
  logic       ready;
  tick_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/srg_target_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface srg_target_if import srg_pkg::*; ();
  logic         valid;
  logic         ready;
  target_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/srg_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface srg_cfg_if import srg_pkg::*; ();
  logic                valid;
  logic                ready;
  cfg_index_t          index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/srg_slew.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srg_slew import srg_pkg::*; (
  input  wire logic signed [ValW-1:0] command,
  input  wire logic signed [ValW-1:0] setpoint,
  input  wire logic [StepW-1:0]       ramp_step,
  output logic signed [ValW-1:0]      ramped
);

  logic signed [ValW:0]   gap;
  logic [ValW:0]          mag;
  logic signed [ValW+1:0] step_s;
  logic signed [ValW+1:0] up_sum;
  logic signed [ValW+1:0] down_sum;

  always_comb begin
    gap      = (ValW+1)'(command) - (ValW+1)'(setpoint);
    mag      = gap[ValW] ? (ValW+1)'(0) - gap : gap;
    step_s   = $signed({{(ValW+2-StepW){1'b0}}, ramp_step});
    up_sum   = (ValW+2)'(setpoint) + step_s;
    down_sum = (ValW+2)'(setpoint) - step_s;
    // A gap smaller than one step snaps straight onto the command.
    if (mag < {{(ValW+1-StepW){1'b0}}, ramp_step}) begin
      ramped = command;
    end else if (!gap[ValW] && gap != '0) begin
      ramped = sat32(up_sum);
    end else begin
      ramped = sat32(down_sum);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srg_integ.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srg_integ import srg_pkg::*; (
  input  wire logic signed [ValW-1:0] acc,
  input  wire logic signed [ValW-1:0] rate,
  input  wire logic [TickW-1:0]       tick_period,
  output logic signed [ValW-1:0]      sum
);

  localparam int unsigned ProdW = ValW + TickW + 1;

  logic signed [ProdW-1:0] prod;
  logic signed [ValW:0]    scaled;
  logic signed [ValW+1:0]  total;

  always_comb begin
    prod   = ProdW'(rate) * ProdW'($signed({1'b0, tick_period}));
    // Dropping the low fraction bits of a signed product rounds toward minus infinity.
    scaled = prod[ProdW-1:TickW];
    total  = (ValW+2)'(acc) + (ValW+2)'(scaled);
    sum    = sat32(total);
  end

endmodule

`default_nettype wire

// ===== hdl/srg_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srg_window import srg_pkg::*; (
  input  wire logic signed [ValW-1:0] value,
  input  wire logic signed [ValW-1:0] center,
  input  wire logic [WinW-1:0]        window,
  output logic signed [ValW-1:0]      clamped
);

  logic signed [ValW:0]   dev;
  logic signed [ValW:0]   win_pos;
  logic signed [ValW:0]   win_neg;
  logic signed [ValW+1:0] upper;
  logic signed [ValW+1:0] lower;

  always_comb begin
    dev     = (ValW+1)'(value) - (ValW+1)'(center);
    win_pos = $signed({{(ValW+1-WinW){1'b0}}, window});
    win_neg = (ValW+1)'(0) - win_pos;
    upper   = (ValW+2)'(center) + (ValW+2)'(win_pos);
    lower   = (ValW+2)'(center) - (ValW+2)'(win_pos);
    if (dev > win_pos) begin
      clamped = sat32(upper);
    end else if (dev < win_neg) begin
      clamped = sat32(lower);
    end else begin
      clamped = value;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/setpoint_ramp_generator.sv =====
// Channel  Role    Word
// tick     sink    speed_cmd, yaw_rate_cmd, measured_position, measured_speed
// target   source  speed_target, position_target, yaw_target
// cfg      sink    index, data (ramp step, tick period, two clamp windows)
//
// A tick word is registered on entry and, once the output register can advance,
// produces its target word there. One word is taken every cycle unless the
// output stalls; the setpoint registers feed back through one combinational
// pass (slew, tick-period multiply, saturating add, clamp).
// Reset is synchronous; it clears the setpoints and restores register defaults.
// A stalled output holds its word, and the input register refills as soon as it moves.
`timescale 1ns / 1ps
`default_nettype none

module setpoint_ramp_generator import srg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  srg_tick_if.sink        tick,
  srg_target_if.source    target,
  srg_cfg_if.sink         cfg
);

  logic [StepW-1:0] ramp_step;
  logic [TickW-1:0] tick_period;
  logic [WinW-1:0]  position_window;
  logic [WinW-1:0]  speed_window;

  logic signed [ValW-1:0] speed_setpoint;
  logic signed [ValW-1:0] position_setpoint;
  logic signed [ValW-1:0] yaw_setpoint;

  logic       in_valid;
  tick_word_t in_word;
  logic       out_valid;
  target_word_t out_word;

  logic advance;
  logic fire;

  logic signed [ValW-1:0] speed_ramped;
  logic signed [ValW-1:0] position_integ;
  logic signed [ValW-1:0] position_next;
  logic signed [ValW-1:0] speed_next;
  logic signed [ValW-1:0] yaw_next;

  assign advance    = !out_valid || target.ready;
  assign fire       = in_valid && advance;
  assign tick.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  assign target.valid = out_valid;
  assign target.data  = out_word;

  srg_slew u_slew (
    .command   (in_word.speed_cmd),
    .setpoint  (speed_setpoint),
    .ramp_step (ramp_step),
    .ramped    (speed_ramped)
  );

  // Position integrates the ramped speed before the speed clamp.
  srg_integ u_pos_integ (
    .acc         (position_setpoint),
    .rate        (speed_ramped),
    .tick_period (tick_period),
    .sum         (position_integ)
  );

  srg_window u_pos_window (
    .value   (position_integ),
    .center  (in_word.measured_position),
    .window  (position_window),
    .clamped (position_next)
  );

  srg_window u_speed_window (
    .value   (speed_ramped),
    .center  (in_word.measured_speed),
    .window  (speed_window),
    .clamped (speed_next)
  );

  srg_integ u_yaw_integ (
    .acc         (yaw_setpoint),
    .rate        (in_word.yaw_rate_cmd),
    .tick_period (tick_period),
    .sum         (yaw_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step       <= RampStepReset;
      tick_period     <= TickPeriodReset;
      position_window <= PositionWindowReset;
      speed_window    <= SpeedWindowReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RAMP_STEP:       ramp_step       <= cfg.data[StepW-1:0];
        CFG_TICK_PERIOD:     tick_period     <= cfg.data[TickW-1:0];
        CFG_POSITION_WINDOW: position_window <= cfg.data[WinW-1:0];
        CFG_SPEED_WINDOW:    speed_window    <= cfg.data[WinW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
    if (tick.ready && tick.valid) begin
      in_word <= tick.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      speed_setpoint    <= '0;
      position_setpoint <= '0;
      yaw_setpoint      <= '0;
    end else begin
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        speed_setpoint    <= speed_next;
        position_setpoint <= position_next;
        yaw_setpoint      <= yaw_next;
      end
    end
    if (fire) begin
      out_word.speed_target    <= speed_next;
      out_word.position_target <= position_next;
      out_word.yaw_target      <= yaw_next;
    end
  end

`ifndef SYNTHESIS
  logic signed [ValW:0] speed_dev;
  logic signed [ValW:0] speed_win_s;

  assign speed_dev   = (ValW+1)'(speed_next) - (ValW+1)'(in_word.measured_speed);
  assign speed_win_s = $signed({{(ValW+1-WinW){1'b0}}, speed_window});

  a_fire_fills_output: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed word did not reach the output register");

  a_input_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_word))
    else $error("input register changed while the output was stalled");

  a_state_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(speed_setpoint) && $stable(position_setpoint) &&
              $stable(yaw_setpoint))
    else $error("setpoint changed without a processed word");

  a_speed_in_window: assert property (@(posedge clk) disable iff (rst)
    fire |-> speed_dev <= speed_win_s && speed_dev >= -speed_win_s)
    else $error("speed target outside the measured speed window");
`endif

endmodule

`default_nettype wire
